>>> design/mgr_pkg.sv
// ----------------------------------------------------------------------------
// mgr_pkg
// Types and codes shared by the mode governor blocks.
// ----------------------------------------------------------------------------
package mgr_pkg;

  localparam int IN_W       = 184;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] MODE_BALANCED = 2'd0;
  localparam logic [1:0] MODE_MEMORY   = 2'd1;
  localparam logic [1:0] MODE_UTIL     = 2'd2;

  localparam logic [2:0] WHY_NONE       = 3'd0;
  localparam logic [2:0] WHY_ERROR      = 3'd1;
  localparam logic [2:0] WHY_PRESSURE   = 3'd2;
  localparam logic [2:0] WHY_LATENCY    = 3'd3;
  localparam logic [2:0] WHY_THROUGHPUT = 3'd4;

  localparam logic [2:0] REG_START_MODE     = 3'd0;
  localparam logic [2:0] REG_SWITCH_ENABLES = 3'd1;
  localparam logic [2:0] REG_DWELL          = 3'd2;
  localparam logic [2:0] REG_COOLDOWN       = 3'd3;
  localparam logic [2:0] REG_RUN_LIMIT      = 3'd4;
  localparam logic [2:0] REG_LAT_MARGIN     = 3'd5;
  localparam logic [2:0] REG_TP_MARGIN      = 3'd6;
  localparam logic [2:0] REG_PRESS_LIMIT    = 3'd7;

  typedef struct packed {
    logic [1:0]  switch_enables;
    logic [15:0] dwell_windows;
    logic [15:0] cooldown_windows;
    logic [15:0] breach_run_limit;
    logic [15:0] latency_margin;
    logic [15:0] throughput_margin;
    logic [15:0] pressure_score_limit;
  } cfg_t;

  typedef struct packed {
    logic        runtime_fault;
    logic [15:0] pressure_level;
    logic [15:0] pressure_event_count;
    logic [15:0] remat_count;
    logic [31:0] baseline_latency;
    logic [31:0] observed_latency;
    logic [31:0] baseline_rate;
    logic [31:0] observed_rate;
  } window_t;

  typedef struct packed {
    logic [1:0] advised_mode;
    logic [2:0] advised_reason;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  mode_out;
    logic [2:0]  last_reason_out;
    logic [1:0]  advised_mode;
    logic [2:0]  advised_reason;
    logic [31:0] rollback_tally;
  } result_t;

endpackage

>>> design/mgr_classify.sv
// ----------------------------------------------------------------------------
// mgr_classify
// Priority breach classification of one metrics window.
// ----------------------------------------------------------------------------
module mgr_classify #(
  parameter logic [15:0] PRESSURE_EVENT_LIMIT = 16'd1,
  parameter logic [15:0] REMAT_LIMIT          = 16'd4
) (
  input  mgr_pkg::window_t  win,
  input  mgr_pkg::cfg_t     cfg,
  output mgr_pkg::verdict_t verdict
);

  logic [48:0] lat_lhs;
  logic [48:0] lat_rhs;
  logic [48:0] tp_lhs;
  logic [48:0] tp_rhs;
  logic [16:0] lat_scale;
  logic [16:0] tp_scale;
  logic        pressure;
  logic        latency;
  logic        throughput;

  assign lat_scale = 17'h10000 + {1'b0, cfg.latency_margin};
  assign tp_scale  = 17'h10000 - {1'b0, cfg.throughput_margin};

  assign lat_lhs = {1'b0, win.observed_latency, 16'h0000};
  assign tp_lhs  = {1'b0, win.observed_rate, 16'h0000};
  assign lat_rhs = win.baseline_latency * lat_scale;
  assign tp_rhs  = win.baseline_rate * tp_scale;

  assign pressure = (win.pressure_level > cfg.pressure_score_limit) ||
                    (win.pressure_event_count >= PRESSURE_EVENT_LIMIT) ||
                    (win.remat_count >= REMAT_LIMIT);
  assign latency    = (win.baseline_latency != 32'd0) && (lat_lhs > lat_rhs);
  assign throughput = (win.baseline_rate != 32'd0) && (tp_lhs < tp_rhs);

  always_comb begin
    if (win.runtime_fault) begin
      verdict = '{advised_mode: mgr_pkg::MODE_BALANCED, advised_reason: mgr_pkg::WHY_ERROR};
    end else if (pressure) begin
      verdict = '{advised_mode: mgr_pkg::MODE_MEMORY, advised_reason: mgr_pkg::WHY_PRESSURE};
    end else if (latency) begin
      verdict = '{advised_mode: mgr_pkg::MODE_BALANCED, advised_reason: mgr_pkg::WHY_LATENCY};
    end else if (throughput) begin
      verdict = '{advised_mode: mgr_pkg::MODE_UTIL, advised_reason: mgr_pkg::WHY_THROUGHPUT};
    end else begin
      verdict = '{advised_mode: mgr_pkg::MODE_BALANCED, advised_reason: mgr_pkg::WHY_NONE};
    end
  end

endmodule

>>> design/mgr_state.sv
// ----------------------------------------------------------------------------
// mgr_state
// Governor state: dwell, cooldown, breach run, rollback and mode switching.
// ----------------------------------------------------------------------------
module mgr_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              reinit,
  input  logic [1:0]        reinit_mode,
  input  mgr_pkg::cfg_t     cfg,
  input  mgr_pkg::verdict_t verdict,
  output mgr_pkg::result_t  result
);

  logic [1:0]  mode_reg;
  logic [15:0] dwell_count;
  logic [15:0] cooldown_count;
  logic [15:0] breach_run;
  logic [31:0] rollback_total;
  logic [2:0]  last_reason;

  logic [1:0]  mode_reg_next;
  logic [15:0] dwell_count_next;
  logic [15:0] cooldown_count_next;
  logic [15:0] breach_run_next;
  logic [31:0] rollback_total_next;
  logic [2:0]  last_reason_next;

  logic [15:0] dwell_tick;
  logic [15:0] cool_tick;
  logic [15:0] run_tick;
  logic        breached;

  always_comb begin
    dwell_tick = (dwell_count != 16'hFFFF) ? dwell_count + 16'd1 : dwell_count;
    cool_tick  = (cooldown_count != 16'd0) ? cooldown_count - 16'd1 : cooldown_count;
    breached   = verdict.advised_reason != mgr_pkg::WHY_NONE;
    run_tick   = !breached ? 16'd0 :
                 (breach_run != 16'hFFFF) ? breach_run + 16'd1 : breach_run;

    mode_reg_next       = mode_reg;
    dwell_count_next    = dwell_tick;
    cooldown_count_next = cool_tick;
    breach_run_next     = run_tick;
    rollback_total_next = rollback_total;
    last_reason_next    = last_reason;

    if (cfg.switch_enables[1] && (run_tick >= cfg.breach_run_limit)) begin
      last_reason_next    = verdict.advised_reason;
      rollback_total_next = (rollback_total != 32'hFFFF_FFFF) ?
                            rollback_total + 32'd1 : rollback_total;
      mode_reg_next       = mgr_pkg::MODE_BALANCED;
      dwell_count_next    = 16'd0;
      cooldown_count_next = cfg.cooldown_windows;
      breach_run_next     = 16'd0;
    end else if (cfg.switch_enables[0] && (cool_tick == 16'd0) &&
                 (dwell_tick >= cfg.dwell_windows) &&
                 (verdict.advised_mode != mode_reg)) begin
      mode_reg_next       = verdict.advised_mode;
      dwell_count_next    = 16'd0;
      cooldown_count_next = cfg.cooldown_windows;
      breach_run_next     = 16'd0;
    end

    result.mode_out        = mode_reg_next;
    result.last_reason_out = last_reason_next;
    result.advised_mode    = verdict.advised_mode;
    result.advised_reason  = verdict.advised_reason;
    result.rollback_tally  = rollback_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= mgr_pkg::MODE_BALANCED;
      dwell_count    <= 16'd0;
      cooldown_count <= 16'd0;
      breach_run     <= 16'd0;
      rollback_total <= 32'd0;
      last_reason    <= mgr_pkg::WHY_NONE;
    end else if (reinit) begin
      mode_reg       <= (reinit_mode <= mgr_pkg::MODE_UTIL) ? reinit_mode :
                        mgr_pkg::MODE_BALANCED;
      dwell_count    <= 16'd0;
      cooldown_count <= 16'd0;
      breach_run     <= 16'd0;
      rollback_total <= 32'd0;
      last_reason    <= mgr_pkg::WHY_NONE;
    end else if (step) begin
      mode_reg       <= mode_reg_next;
      dwell_count    <= dwell_count_next;
      cooldown_count <= cooldown_count_next;
      breach_run     <= breach_run_next;
      rollback_total <= rollback_total_next;
      last_reason    <= last_reason_next;
    end
  end

endmodule

>>> design/mode_governor_with_rollback_top.sv
// ----------------------------------------------------------------------------
// mode_governor_with_rollback_top
// Mode governor with breach tracking and hard rollback to balanced.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one metrics window per transaction. Master stream m_*:
//   one result per window, in order. Configuration is written through
//   cfg_we / cfg_index / cfg_data; the user must do so only while the block
//   is idle (the block does not enforce it). A write to the start mode
//   register (index 0) re-initialises the governor state.
//   Path: a window goes through the input register, then the result register.
//   Throughput: one window per cycle unless m_* stalls, set by the single pass
//   of compares and two 32x17 multiplies between input and result registers.
//   Reset: rst clears both pipeline stages, loads the register defaults and
//   puts the governor in balanced mode with all counters at zero.
//   Stall: when m_tready is low the result register holds; an empty input
//   register still takes one more window, after which s_tready drops until
//   the result is taken.
// ----------------------------------------------------------------------------
module mode_governor_with_rollback_top #(
  parameter logic [15:0] PRESSURE_EVENT_LIMIT = 16'd1,
  parameter logic [15:0] REMAT_LIMIT          = 16'd4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // runtime_fault, pressure_level, pressure_event_count, remat_count,
  // baseline_latency, observed_latency, baseline_rate, observed_rate
  input  logic [mgr_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mode_out, last_reason_out, advised_mode, advised_reason, rollback_tally
  output logic [mgr_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            cfg_we,
  input  logic [mgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mgr_pkg::cfg_t     cfg;
  mgr_pkg::window_t  win;
  mgr_pkg::verdict_t verdict;
  mgr_pkg::result_t  result;
  mgr_pkg::result_t  res_q;
  logic              in_valid;
  logic              step;
  logic              reinit;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;
  assign reinit   = cfg_we && (cfg_index == mgr_pkg::REG_START_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.switch_enables       <= 2'd3;
      cfg.dwell_windows        <= 16'd4;
      cfg.cooldown_windows     <= 16'd2;
      cfg.breach_run_limit     <= 16'd2;
      cfg.latency_margin       <= 16'd5243;
      cfg.throughput_margin    <= 16'd3277;
      cfg.pressure_score_limit <= 16'd13107;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgr_pkg::REG_SWITCH_ENABLES: cfg.switch_enables       <= cfg_data[1:0];
        mgr_pkg::REG_DWELL:          cfg.dwell_windows        <= cfg_data;
        mgr_pkg::REG_COOLDOWN:       cfg.cooldown_windows     <= cfg_data;
        mgr_pkg::REG_RUN_LIMIT:      cfg.breach_run_limit     <= cfg_data;
        mgr_pkg::REG_LAT_MARGIN:     cfg.latency_margin       <= cfg_data;
        mgr_pkg::REG_TP_MARGIN:      cfg.throughput_margin    <= cfg_data;
        mgr_pkg::REG_PRESS_LIMIT:    cfg.pressure_score_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      win.runtime_fault        <= s_tdata[0];
      win.pressure_level       <= s_tdata[16:1];
      win.pressure_event_count <= s_tdata[32:17];
      win.remat_count          <= s_tdata[48:33];
      win.baseline_latency     <= s_tdata[80:49];
      win.observed_latency     <= s_tdata[112:81];
      win.baseline_rate        <= s_tdata[144:113];
      win.observed_rate        <= s_tdata[176:145];
    end
  end

  mgr_classify #(
    .PRESSURE_EVENT_LIMIT (PRESSURE_EVENT_LIMIT),
    .REMAT_LIMIT          (REMAT_LIMIT)
  ) u_classify (
    .win     (win),
    .cfg     (cfg),
    .verdict (verdict)
  );

  mgr_state u_state (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .reinit      (reinit),
    .reinit_mode (cfg_data[1:0]),
    .cfg         (cfg),
    .verdict     (verdict),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign m_tdata = {6'b000000, res_q.rollback_tally, res_q.advised_reason,
                    res_q.advised_mode, res_q.last_reason_out, res_q.mode_out};

endmodule

>>> design/mgr_checker.sv
// ----------------------------------------------------------------------------
// mgr_checker
// Port-level checks on the mode governor, bound to the top level.
// ----------------------------------------------------------------------------
module mgr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mgr_pkg::OUT_W-1:0]      m_tdata
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[6:5] != 2'd3))
    else $error("unused mode code on output");

  a_advice_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9:7] == mgr_pkg::WHY_PRESSURE) |->
      (m_tdata[6:5] == mgr_pkg::MODE_MEMORY))
    else $error("pressure breach without memory-first advice");

endmodule

bind mode_governor_with_rollback_top mgr_checker u_mgr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
